>>> hw/rtl/mbce_pkg.sv
// ----------------------------------------------------------------------------
// mbce_pkg: shared types and constants for the mono bitmap color expander
// Field widths, register codes and reset values, the per-item and per-row
// request structs, and helpers for the pixel byte count and data mask.
// ----------------------------------------------------------------------------
package mbce_pkg;

    // Lanes: one per bit of a bitmap byte
    localparam int LANES = 8;

    // Default parameter values
    localparam int MAX_DIM_DEF      = 4096;
    localparam int FB_ADDR_BITS_DEF = 26;

    // Field widths
    localparam int COORD_W = 13;
    localparam int DIM_W   = 13;
    localparam int PIX_W   = 32;
    localparam int COL_W   = 10;
    localparam int XPOS_W  = 15;
    localparam int ROWOFF_W = 28;
    localparam int BPP_W   = 3;
    localparam int PITCH_W = 15;

    // Register codes
    localparam logic [1:0] REG_BPP    = 2'd0;
    localparam logic [1:0] REG_PITCH  = 2'd1;
    localparam logic [1:0] REG_SCR_W  = 2'd2;
    localparam logic [1:0] REG_SCR_H  = 2'd3;

    // Register reset values
    localparam logic [BPP_W-1:0]   BPP_RST   = 3'd4;
    localparam logic [PITCH_W-1:0] PITCH_RST = 15'd4096;
    localparam logic [DIM_W-1:0]   SCR_W_RST = 13'd1024;
    localparam logic [DIM_W-1:0]   SCR_H_RST = 13'd768;

    // One input request as it arrives on the stream
    typedef struct packed {
        logic               first;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic [DIM_W-1:0]   bitmap_width;
        logic [DIM_W-1:0]   bitmap_height;
        logic [PIX_W-1:0]   fg_pixel;
        logic [PIX_W-1:0]   bg_pixel;
        logic [7:0]         bitmap_byte;
    } in_item_t;

    // Row-level results handed from the front stage to the lanes
    typedef struct packed {
        logic                row_vis;
        logic [XPOS_W-1:0]   x0;
        logic [DIM_W-1:0]    col_base;
        logic [DIM_W-1:0]    bw;
        logic [ROWOFF_W-1:0] row_off;
        logic [PIX_W-1:0]    fg;
        logic [PIX_W-1:0]    bg;
        logic [7:0]          bits;
    } row_info_t;

    // Saturate the bytes-per-pixel register to 1..4
    function automatic logic [BPP_W-1:0] bpp_sat(input logic [BPP_W-1:0] v);
        logic [BPP_W-1:0] r;
        begin
            if (v == 3'd0)
            begin
                r = 3'd1;
            end
            else if (v > 3'd4)
            begin
                r = 3'd4;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

    // Keep only the bytes that one pixel uses
    function automatic logic [PIX_W-1:0] pixel_mask(input logic [BPP_W-1:0] bpp);
        logic [PIX_W-1:0] m;
        begin
            case (bpp)
                3'd1:    m = 32'h0000_00FF;
                3'd2:    m = 32'h0000_FFFF;
                3'd3:    m = 32'h00FF_FFFF;
                default: m = 32'hFFFF_FFFF;
            endcase
            return m;
        end
    endfunction

endpackage

>>> hw/rtl/mbce_front.sv
// ----------------------------------------------------------------------------
// mbce_front: position tracker and row stage
// Tracks row and byte column across a blit, clamps the bitmap size, works
// out the row offset and the left pixel column, and registers the result.
// ----------------------------------------------------------------------------
module mbce_front #(
    parameter int MAX_DIM = mbce_pkg::MAX_DIM_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mbce_pkg::in_item_t              in_item,
    input  logic [mbce_pkg::PITCH_W-1:0]    line_pitch,
    input  logic [mbce_pkg::DIM_W-1:0]      screen_height,
    input  logic                            adv_ok,
    output logic                            out_valid,
    output mbce_pkg::row_info_t             out_info
);

    logic [mbce_pkg::DIM_W-1:0]  row_reg, row_next;
    logic [mbce_pkg::COL_W-1:0]  col_reg, col_next;
    logic                        valid_reg, valid_next;
    mbce_pkg::row_info_t         info_reg, info_next;

    logic                        in_fire;
    logic [mbce_pkg::DIM_W-1:0]  rc;
    logic [mbce_pkg::COL_W-1:0]  bc;
    logic [mbce_pkg::DIM_W-1:0]  bw;
    logic [mbce_pkg::DIM_W-1:0]  bh;
    logic                        active;
    logic [10:0]                 row_bytes;
    logic [10:0]                 col_inc;
    logic [13:0]                 bw_round;
    logic [mbce_pkg::XPOS_W-1:0] y;
    logic                        y_vis;
    logic [mbce_pkg::DIM_W-1:0]  col_base;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = !valid_reg || adv_ok;

    // Start of blit clears the position before this byte
    always_comb
    begin
        rc = in_item.first ? '0 : row_reg;
        bc = in_item.first ? '0 : col_reg;
    end

    // Clamp bitmap size
    always_comb
    begin
        bw = (32'(in_item.bitmap_width) > MAX_DIM) ? 13'(MAX_DIM) : in_item.bitmap_width;
        bh = (32'(in_item.bitmap_height) > MAX_DIM) ? 13'(MAX_DIM) : in_item.bitmap_height;
    end

    // Row geometry and visibility
    always_comb
    begin
        active    = (bw != '0) && (bh != '0) && (rc < bh);
        bw_round  = {1'b0, bw} + 14'd7;
        row_bytes = bw_round[13:3];
        col_inc   = {1'b0, bc} + 11'd1;
        y         = {{2{in_item.dest_y[12]}}, in_item.dest_y} + {2'b00, rc};
        y_vis     = !y[14] && ({1'b0, y[13:0]} < {2'b00, screen_height});
        col_base  = {bc, 3'b000};
    end

    // Build the row request for the lanes
    always_comb
    begin
        info_next.row_vis  = active && y_vis;
        info_next.x0       = {{2{in_item.dest_x[12]}}, in_item.dest_x} + {2'b00, col_base};
        info_next.col_base = col_base;
        info_next.bw       = bw;
        info_next.row_off  = {15'd0, y[12:0]} * {13'd0, line_pitch};
        info_next.fg       = in_item.fg_pixel;
        info_next.bg       = in_item.bg_pixel;
        info_next.bits     = in_item.bitmap_byte;
    end

    // Advance the position on each accepted byte of a live blit
    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (in_fire)
        begin
            row_next = rc;
            col_next = bc;
            if (active)
            begin
                if (col_inc >= row_bytes)
                begin
                    col_next = '0;
                    row_next = rc + 13'd1;
                end
                else
                begin
                    col_next = col_inc[mbce_pkg::COL_W-1:0];
                end
            end
        end
    end

    // Stage valid: load on accept, drop when the lanes hand off
    always_comb
    begin
        if (in_fire)
        begin
            valid_next = 1'b1;
        end
        else if (adv_ok)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            info_reg <= info_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_info  = info_reg;

endmodule

>>> hw/rtl/mbce_lane.sv
// ----------------------------------------------------------------------------
// mbce_lane: one pixel of a bitmap byte
// Decides whether the pixel is inside the bitmap and on screen, and forms
// its byte offset and masked pixel value.
// ----------------------------------------------------------------------------
module mbce_lane #(
    parameter int FB_ADDR_BITS = mbce_pkg::FB_ADDR_BITS_DEF
) (
    input  mbce_pkg::row_info_t           info,
    input  logic [2:0]                    ofs,
    input  logic [mbce_pkg::DIM_W-1:0]    screen_width,
    input  logic [mbce_pkg::BPP_W-1:0]    bpp,
    input  logic [mbce_pkg::PIX_W-1:0]    data_mask,
    output logic                          hit,
    output logic [FB_ADDR_BITS-1:0]       offset,
    output logic [mbce_pkg::PIX_W-1:0]    data
);

    logic [mbce_pkg::DIM_W-1:0]  col;
    logic [mbce_pkg::XPOS_W-1:0] x;
    logic [12:0]                 x13;
    logic [14:0]                 xb;
    logic [28:0]                 off_sum;
    logic                        pix_bit;

    // Column and screen position of this pixel
    always_comb
    begin
        col = info.col_base + {10'd0, ofs};
        x   = info.x0 + {12'd0, ofs};
        x13 = x[12:0];
        hit = info.row_vis && (col < info.bw) && !x[14]
              && ({1'b0, x[13:0]} < {2'b00, screen_width});
    end

    // Scale column by pixel size with shifts
    always_comb
    begin
        case (bpp)
            3'd1:    xb = {2'b00, x13};
            3'd2:    xb = {1'b0, x13, 1'b0};
            3'd3:    xb = {2'b00, x13} + {1'b0, x13, 1'b0};
            default: xb = {x13, 2'b00};
        endcase
        off_sum = {1'b0, info.row_off} + {14'd0, xb};
        offset  = FB_ADDR_BITS'({3'b000, off_sum});
    end

    // Pick foreground or background
    always_comb
    begin
        pix_bit = info.bits[3'd7 - ofs];
        data    = (pix_bit ? info.fg : info.bg) & data_mask;
    end

endmodule

>>> hw/rtl/mbce_merge.sv
// ----------------------------------------------------------------------------
// mbce_merge: write buffer and sequencer
// Holds the visible writes of one byte and hands them out one per cycle while
// out_ready is high, leftmost first, flagging the last one.
// ----------------------------------------------------------------------------
module mbce_merge #(
    parameter int FB_ADDR_BITS = mbce_pkg::FB_ADDR_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load_valid,
    input  logic [mbce_pkg::LANES-1:0]   in_hit,
    input  logic [FB_ADDR_BITS-1:0]      in_off  [mbce_pkg::LANES],
    input  logic [mbce_pkg::PIX_W-1:0]   in_data [mbce_pkg::LANES],
    input  logic [mbce_pkg::BPP_W-1:0]   in_bytes,
    output logic                         buf_free,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [FB_ADDR_BITS-1:0]      out_off,
    output logic [mbce_pkg::PIX_W-1:0]   out_data,
    output logic [mbce_pkg::BPP_W-1:0]   out_bytes,
    output logic                         out_last
);

    logic [mbce_pkg::LANES-1:0] mask_reg, mask_next;
    logic [FB_ADDR_BITS-1:0]    off_reg  [mbce_pkg::LANES];
    logic [mbce_pkg::PIX_W-1:0] data_reg [mbce_pkg::LANES];
    logic [mbce_pkg::BPP_W-1:0] bytes_reg;

    logic [mbce_pkg::LANES-1:0] sel;
    logic [mbce_pkg::LANES-1:0] rest;
    logic                       out_fire;
    logic                       load;

    // Pick the leftmost pending write
    always_comb
    begin
        sel      = mask_reg & (~mask_reg + 8'd1);
        rest     = mask_reg & ~sel;
        out_off  = '0;
        out_data = '0;
        for (int i = 0; i < mbce_pkg::LANES; i++)
        begin
            if (sel[i])
            begin
                out_off  = out_off | off_reg[i];
                out_data = out_data | data_reg[i];
            end
        end
    end

    assign out_valid = (mask_reg != '0);
    assign out_last  = (rest == '0);
    assign out_bytes = bytes_reg;
    assign out_fire  = out_valid && out_ready;
    assign buf_free  = (mask_reg == '0) || (out_fire && out_last);
    assign load      = load_valid && buf_free && (in_hit != '0);

    // Refill on load, otherwise retire the sent write
    always_comb
    begin
        if (load)
        begin
            mask_next = in_hit;
        end
        else if (out_fire)
        begin
            mask_next = rest;
        end
        else
        begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= in_bytes;
            for (int i = 0; i < mbce_pkg::LANES; i++)
            begin
                off_reg[i]  <= in_off[i];
                data_reg[i] <= in_data[i];
            end
        end
    end

endmodule

>>> hw/rtl/mono_bitmap_color_expander_core.sv
// ----------------------------------------------------------------------------
// mono_bitmap_color_expander_core: 1 bpp bitmap to framebuffer pixel writes
// The row stage registers each byte; its writes then leave from the write buffer.
// Throughput: a byte makes 0..8 visible writes, sent one at a time on the single write output;
// the row stage and 8 lanes take a byte/cycle unless a byte with writes waits for a busy buffer.
// Reset: clears row/column, pipeline and buffer; registers take defaults.
// ----------------------------------------------------------------------------
module mono_bitmap_color_expander_core #(
    parameter int MAX_DIM      = mbce_pkg::MAX_DIM_DEF,
    parameter int FB_ADDR_BITS = mbce_pkg::FB_ADDR_BITS_DEF,
    localparam int OUT_W       = ((FB_ADDR_BITS + 35 + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // dest_x[12:0], dest_y[25:13], bitmap_width[38:26], bitmap_height[51:39],
    // fg_pixel[83:52], bg_pixel[115:84], bitmap_byte[123:116], zero pad
    input  logic [127:0]      s_tdata,
    // first_of_blit
    input  logic              s_tuser,
    // Output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // write_offset, pixel_data (32), pixel_bytes (3), zero pad
    output logic [OUT_W-1:0]  m_tdata,
    output logic              m_tlast,
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [mbce_pkg::BPP_W-1:0]   bpp_reg;
    logic [mbce_pkg::PITCH_W-1:0] pitch_reg;
    logic [mbce_pkg::DIM_W-1:0]   scr_w_reg;
    logic [mbce_pkg::DIM_W-1:0]   scr_h_reg;
    logic [1:0]                   reg_idx;
    logic                         cfg_wr;

    mbce_pkg::in_item_t           item;
    mbce_pkg::row_info_t          s1_info;
    logic                         s1_valid;
    logic                         adv_ok;
    logic                         buf_free;
    logic [mbce_pkg::BPP_W-1:0]   bpp_eff;
    logic [mbce_pkg::PIX_W-1:0]   data_mask;

    logic [mbce_pkg::LANES-1:0]   lane_hit;
    logic [FB_ADDR_BITS-1:0]      lane_off  [mbce_pkg::LANES];
    logic [mbce_pkg::PIX_W-1:0]   lane_data [mbce_pkg::LANES];

    logic [FB_ADDR_BITS-1:0]      m_off;
    logic [mbce_pkg::PIX_W-1:0]   m_data;
    logic [mbce_pkg::BPP_W-1:0]   m_bytes;

    // Register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= mbce_pkg::BPP_RST;
            pitch_reg <= mbce_pkg::PITCH_RST;
            scr_w_reg <= mbce_pkg::SCR_W_RST;
            scr_h_reg <= mbce_pkg::SCR_H_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                mbce_pkg::REG_BPP:   bpp_reg   <= pwdata[2:0];
                mbce_pkg::REG_PITCH: pitch_reg <= pwdata[14:0];
                mbce_pkg::REG_SCR_W: scr_w_reg <= pwdata[12:0];
                mbce_pkg::REG_SCR_H: scr_h_reg <= pwdata[12:0];
                default:             bpp_reg   <= bpp_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            mbce_pkg::REG_BPP:   prdata = {29'd0, bpp_reg};
            mbce_pkg::REG_PITCH: prdata = {17'd0, pitch_reg};
            mbce_pkg::REG_SCR_W: prdata = {19'd0, scr_w_reg};
            mbce_pkg::REG_SCR_H: prdata = {19'd0, scr_h_reg};
            default:             prdata = '0;
        endcase
    end

    // Unpack the input request
    always_comb
    begin
        item.first         = s_tuser;
        item.dest_x        = s_tdata[12:0];
        item.dest_y        = s_tdata[25:13];
        item.bitmap_width  = s_tdata[38:26];
        item.bitmap_height = s_tdata[51:39];
        item.fg_pixel      = s_tdata[83:52];
        item.bg_pixel      = s_tdata[115:84];
        item.bitmap_byte   = s_tdata[123:116];
    end

    assign bpp_eff   = mbce_pkg::bpp_sat(bpp_reg);
    assign data_mask = mbce_pkg::pixel_mask(bpp_eff);

    // Row stage hands off when the byte is empty or the buffer frees up
    assign adv_ok = (lane_hit == '0) || buf_free;

    mbce_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (item),
        .line_pitch    (pitch_reg),
        .screen_height (scr_h_reg),
        .adv_ok        (adv_ok),
        .out_valid     (s1_valid),
        .out_info      (s1_info)
    );

    // One lane per bit, leftmost pixel in lane 0
    for (genvar g = 0; g < mbce_pkg::LANES; g++)
    begin : g_lane
        mbce_lane #(
            .FB_ADDR_BITS (FB_ADDR_BITS)
        ) u_lane (
            .info         (s1_info),
            .ofs          (3'(g)),
            .screen_width (scr_w_reg),
            .bpp          (bpp_eff),
            .data_mask    (data_mask),
            .hit          (lane_hit[g]),
            .offset       (lane_off[g]),
            .data         (lane_data[g])
        );
    end

    mbce_merge #(
        .FB_ADDR_BITS (FB_ADDR_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (s1_valid),
        .in_hit     (lane_hit),
        .in_off     (lane_off),
        .in_data    (lane_data),
        .in_bytes   (bpp_eff),
        .buf_free   (buf_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_off    (m_off),
        .out_data   (m_data),
        .out_bytes  (m_bytes),
        .out_last   (m_tlast)
    );

    assign m_tdata = OUT_W'({m_bytes, m_data, m_off});

    // Empty row stage always takes a request
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s1_valid |-> s_tready
    ) else $error("input stalled with row stage empty");

    // Held row request stays put while the buffer is busy
    a_row_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid && !adv_ok) |=> (s1_valid && $stable(s1_info))
    ) else $error("row request changed while stalled");

    // Start of blit with zero bitmap width leaves the position cleared
    a_empty_blit: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser && (s_tdata[38:26] == 13'd0))
        |=> ((u_front.row_reg == '0) && (u_front.col_reg == '0))
    ) else $error("empty blit moved the position");

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for mono_bitmap_color_expander_core
// Streams bitmap bytes into the expander with random gaps and output stalls,
// predicts every pixel write with its own expansion model, and compares each
// write field by field. Registers are rewritten over APB between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int OUT_W         = 64;
    localparam int DRAIN_CYCLES  = 16;
    localparam int DIRECTED_MAX  = 20;
    localparam int RANDOM_ITEMS  = 150;
    localparam int PRINT_LIMIT   = 40;

    // One framebuffer pixel write as seen on the output stream
    typedef struct {
        logic [25:0] offset;
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
    } pixel_write_t;

    // Expansion model and queue of pixel writes still to arrive
    class pixel_scoreboard;
        bit [mbce_pkg::BPP_W-1:0]   bpp_reg;
        bit [mbce_pkg::PITCH_W-1:0] pitch_reg;
        bit [mbce_pkg::DIM_W-1:0]   scr_w;
        bit [mbce_pkg::DIM_W-1:0]   scr_h;
        bit [12:0]                  row_cnt;
        bit [9:0]                   byte_col;
        pixel_write_t               writes_due[$];

        function new();
            bpp_reg   = mbce_pkg::BPP_RST;
            pitch_reg = mbce_pkg::PITCH_RST;
            scr_w     = mbce_pkg::SCR_W_RST;
            scr_h     = mbce_pkg::SCR_H_RST;
            row_cnt   = '0;
            byte_col  = '0;
        endfunction

        function void set_reg(input logic [1:0] idx, input logic [31:0] val);
            case (idx)
                mbce_pkg::REG_BPP:   bpp_reg   = val[mbce_pkg::BPP_W-1:0];
                mbce_pkg::REG_PITCH: pitch_reg = val[mbce_pkg::PITCH_W-1:0];
                mbce_pkg::REG_SCR_W: scr_w     = val[mbce_pkg::DIM_W-1:0];
                mbce_pkg::REG_SCR_H: scr_h     = val[mbce_pkg::DIM_W-1:0];
                default:   ;
            endcase
        endfunction

        function int pending();
            return writes_due.size();
        endfunction

        // Expand one accepted bitmap byte into its visible pixel writes
        function void note_request(input mbce_pkg::in_item_t req);
            int           dx;
            int           dy;
            int           bw;
            int           bh;
            int           eff_bpp;
            int           row_bytes;
            int           col;
            int           x;
            int           y;
            int           b;
            bit           stop;
            bit           have_prev;
            logic [31:0]  data_mask;
            logic [31:0]  pix;
            longint       off;
            pixel_write_t w;
            pixel_write_t prev;
            begin
                dx = int'($signed(req.dest_x));
                dy = int'($signed(req.dest_y));
                bw = int'(req.bitmap_width);
                bh = int'(req.bitmap_height);
                if (bw > mbce_pkg::MAX_DIM_DEF)
                begin
                    bw = mbce_pkg::MAX_DIM_DEF;
                end
                if (bh > mbce_pkg::MAX_DIM_DEF)
                begin
                    bh = mbce_pkg::MAX_DIM_DEF;
                end
                eff_bpp = int'(bpp_reg);
                if (eff_bpp == 0)
                begin
                    eff_bpp = 1;
                end
                else if (eff_bpp > 4)
                begin
                    eff_bpp = 4;
                end
                data_mask = (eff_bpp == 4) ? 32'hFFFF_FFFF
                                           : ((32'd1 << (eff_bpp * 8)) - 32'd1);

                if (req.first)
                begin
                    row_cnt  = '0;
                    byte_col = '0;
                end
                // Empty bitmap or bytes past the last row: nothing happens
                if (bw == 0 || bh == 0 || int'(row_cnt) >= bh)
                begin
                    return;
                end

                row_bytes = (bw + 7) / 8;
                y         = dy + int'(row_cnt);
                stop      = 1'b0;
                have_prev = 1'b0;
                for (b = 0; b < 8 && !stop; b++)
                begin
                    col = int'(byte_col) * 8 + b;
                    if (col >= bw)
                    begin
                        // Drop padding bits and everything after them
                        stop = 1'b1;
                    end
                    else
                    begin
                        x = dx + col;
                        if (x >= 0 && y >= 0 && x < int'(scr_w) && y < int'(scr_h))
                        begin
                            pix = req.bitmap_byte[7 - b] ? req.fg_pixel : req.bg_pixel;
                            off = longint'(y) * longint'(pitch_reg)
                                + longint'(x) * longint'(eff_bpp);
                            w.offset = off[25:0];
                            w.data   = pix & data_mask;
                            w.nbytes = eff_bpp[2:0];
                            w.last   = 1'b0;
                            if (have_prev)
                            begin
                                writes_due.push_back(prev);
                            end
                            prev      = w;
                            have_prev = 1'b1;
                        end
                    end
                end
                if (have_prev)
                begin
                    prev.last = 1'b1;
                    writes_due.push_back(prev);
                end

                // Advance to the next byte, wrapping at the end of the row
                if (int'(byte_col) + 1 >= row_bytes)
                begin
                    byte_col = '0;
                    row_cnt  = row_cnt + 13'd1;
                end
                else
                begin
                    byte_col = byte_col + 10'd1;
                end
            end
        endfunction

        // Compare one observed write against the oldest one due
        function bit check_write(input pixel_write_t got, output string why);
            pixel_write_t exp_w;
            begin
                why = "";
                if (writes_due.size() == 0)
                begin
                    $sformat(why, "write off=%h data=%h with nothing due",
                             got.offset, got.data);
                    return 1'b0;
                end
                exp_w = writes_due.pop_front();
                if (got.offset !== exp_w.offset)
                begin
                    $sformat(why, "%s offset %h/%h", why, got.offset, exp_w.offset);
                end
                if (got.data !== exp_w.data)
                begin
                    $sformat(why, "%s data %h/%h", why, got.data, exp_w.data);
                end
                if (got.nbytes !== exp_w.nbytes)
                begin
                    $sformat(why, "%s bytes %0d/%0d", why, got.nbytes, exp_w.nbytes);
                end
                if (got.last !== exp_w.last)
                begin
                    $sformat(why, "%s last %b/%b", why, got.last, exp_w.last);
                end
                return (why == "");
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // dest_x, dest_y, bitmap_width, bitmap_height, fg_pixel, bg_pixel,
    // bitmap_byte, zero pad (lowest bit up)
    logic [127:0]      s_tdata;
    // first_of_blit
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    // write_offset, pixel_data, pixel_bytes, zero pad (lowest bit up)
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    pixel_scoreboard   sb;
    int                err_count;
    int                items_sent;
    bit                tx_quiet;
    bit                rx_quiet;
    int                stall_left;
    int                rx_stall;
    pixel_write_t      rx_got;
    string             rx_why;

    mono_bitmap_color_expander_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Hard stop if the run hangs
    initial
    begin
        #(2_000_000);
        $display("tb_top: errors");
        $finish;
    end

    task automatic report(input string msg);
        begin
            if (err_count < PRINT_LIMIT)
            begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
            err_count++;
        end
    endtask

    // Take pixel writes and stall the output at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tready && m_tvalid === 1'b1)
        begin
            rx_got.offset = m_tdata[25:0];
            rx_got.data   = m_tdata[57:26];
            rx_got.nbytes = m_tdata[60:58];
            rx_got.last   = m_tlast;
            if (!sb.check_write(rx_got, rx_why))
            begin
                report(rx_why);
            end
            rx_stall = rx_quiet ? 0 : $urandom_range(0, 15);
            if (rx_stall > 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= rx_stall - 1;
            end
        end
        else if (!m_tready)
        begin
            if (stall_left == 0)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                stall_left <= stall_left - 1;
            end
        end
    end

    // Send one bitmap byte request, after a random gap unless tx_quiet is set
    task automatic send_req(input logic first, input logic [12:0] dx, input logic [12:0] dy,
                            input logic [12:0] bw, input logic [12:0] bh,
                            input logic [31:0] fg, input logic [31:0] bg,
                            input logic [7:0] bits);
        mbce_pkg::in_item_t req;
        int                 gap;
        begin
            req.first         = first;
            req.dest_x        = dx;
            req.dest_y        = dy;
            req.bitmap_width  = bw;
            req.bitmap_height = bh;
            req.fg_pixel      = fg;
            req.bg_pixel      = bg;
            req.bitmap_byte   = bits;
            gap = tx_quiet ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= first;
            s_tdata  <= {4'b0, bits, bg, fg, bh, bw, dy, dx};
            do
                @(posedge clk);
            while (s_tready !== 1'b1);
            sb.note_request(req);
            items_sent++;
        end
    endtask

    // Hold the input until all due writes are out, then let the pipe settle
    task automatic wait_idle();
        int guard;
        begin
            s_tvalid <= 1'b0;
            guard = 0;
            while (sb.pending() != 0 && guard < 5000)
            begin
                @(posedge clk);
                guard++;
            end
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // One APB write; psel stays high so writes can run back to back
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= val;
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (pready !== 1'b1);
            sb.set_reg(idx, val);
        end
    endtask

    task automatic set_config(input int bpp, input int pitch, input int w, input int h);
        begin
            apb_write(mbce_pkg::REG_BPP, bpp);
            apb_write(mbce_pkg::REG_PITCH, pitch);
            apb_write(mbce_pkg::REG_SCR_W, w);
            apb_write(mbce_pkg::REG_SCR_H, h);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
    endtask

    // Main sequence
    initial
    begin
        int          ph;
        int          phase_end;
        int          cfg_w;
        int          cfg_h;
        int          kind;
        int          bw;
        int          bh;
        int          rb;
        int          total;
        int          cut;
        int          odd_idx;
        int          idx;
        int          dx;
        int          dy;
        logic [31:0] fg;
        logic [31:0] bg;
        bit          pause_done;

        sb         = new();
        err_count  = 0;
        items_sent = 0;
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        pause_done = 1'b0;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset defaults, full byte, empty bitmaps, clipping
        send_req(1'b1, 13'd0, 13'd0, 13'd8, 13'd1, 32'hFFFF_FFFF, 32'h0, 8'hA5);
        send_req(1'b1, 13'd0, 13'd0, 13'd0, 13'd5, 32'h1111_1111, 32'h2222_2222, 8'hFF);
        send_req(1'b1, 13'd0, 13'd0, 13'd5, 13'd0, 32'h1111_1111, 32'h2222_2222, 8'hFF);
        send_req(1'b1, 13'(-3), 13'd0, 13'd8, 13'd2, 32'hDEAD_BEEF, 32'h0BAD_F00D, 8'hFF);
        send_req(1'b0, 13'(-3), 13'd0, 13'd8, 13'd2, 32'hDEAD_BEEF, 32'h0BAD_F00D, 8'h00);
        // Past the last row
        send_req(1'b0, 13'(-3), 13'd0, 13'd8, 13'd2, 32'hDEAD_BEEF, 32'h0BAD_F00D, 8'hFF);
        // Padding bits past the width
        send_req(1'b1, 13'd100, 13'd10, 13'd5, 13'd1, 32'hCAFE_0001, 32'h0, 8'hFF);
        // Width shrinks in the middle of a row
        send_req(1'b1, 13'd0, 13'd0, 13'd16, 13'd2, 32'h0102_0304, 32'hA0B0_C0D0, 8'h0F);
        send_req(1'b0, 13'd0, 13'd0, 13'd8, 13'd2, 32'h0102_0304, 32'hA0B0_C0D0, 8'hFF);
        send_req(1'b0, 13'd0, 13'd0, 13'd16, 13'd2, 32'h0102_0304, 32'hA0B0_C0D0, 8'h3C);
        // Oversized bitmap at the bottom right corner
        send_req(1'b1, 13'd1020, 13'd767, 13'h1FFF, 13'h1FFF, 32'h1234_5678, 32'h9ABC_DEF0,
                 8'h81);
        // Extreme destinations
        send_req(1'b1, 13'h0FFF, 13'h1000, 13'd8, 13'd1, 32'hFFFF_FFFF, 32'h0, 8'h55);
        send_req(1'b1, 13'h1000, 13'h0FFF, 13'd4096, 13'd4096, 32'h0, 32'hFFFF_FFFF, 8'hAA);
        wait_idle();

        // Zero byte size and offsets just below the top of the address space
        set_config(0, 16384, 4096, 4096);
        send_req(1'b1, 13'd4088, 13'd4095, 13'd8, 13'd1, 32'h7654_3210, 32'hFEDC_BA98,
                 8'hC3);
        wait_idle();

        // Byte size above four, widest pitch, right screen edge
        set_config(7, 32767, 4096, 4096);
        send_req(1'b1, 13'd4090, 13'd4000, 13'd12, 13'd1, 32'h8000_0001, 32'h7FFF_FFFE,
                 8'hFF);
        send_req(1'b0, 13'd4090, 13'd4000, 13'd12, 13'd1, 32'h8000_0001, 32'h7FFF_FFFE,
                 8'hF0);
        wait_idle();

        // Zero-size screen clips everything
        set_config(2, 0, 0, 0);
        send_req(1'b1, 13'd0, 13'd0, 13'd8, 13'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        wait_idle();

        // Three-byte pixels on a tiny screen
        set_config(3, 100, 16, 8);
        send_req(1'b1, 13'd10, 13'd7, 13'd16, 13'd2, 32'hAABB_CCDD, 32'h1122_3344, 8'h55);
        send_req(1'b0, 13'd10, 13'd7, 13'd16, 13'd2, 32'hAABB_CCDD, 32'h1122_3344, 8'hAA);
        send_req(1'b0, 13'd10, 13'd7, 13'd16, 13'd2, 32'hAABB_CCDD, 32'h1122_3344, 8'hFF);
        wait_idle();

        // Random phases: mostly well-formed blits, some broken ones and noise
        for (ph = 0; items_sent < DIRECTED_MAX + RANDOM_ITEMS && ph < 50; ph++)
        begin
            case (ph % 5)
                0:
                begin
                    cfg_w = 4096;
                    cfg_h = 4096;
                    set_config(4, 16384, cfg_w, cfg_h);
                end
                1:
                begin
                    cfg_w = $urandom_range(8, 80);
                    cfg_h = $urandom_range(4, 24);
                    set_config(1, 0, cfg_w, cfg_h);
                end
                default:
                begin
                    cfg_w = $urandom_range(8, 80);
                    cfg_h = $urandom_range(4, 24);
                    set_config($urandom_range(0, 7), $urandom_range(0, 32767), cfg_w, cfg_h);
                end
            endcase
            tx_quiet  = (ph % 3 == 2);
            rx_quiet  = (ph % 4 == 3);
            phase_end = items_sent + 28;

            while (items_sent < phase_end && items_sent < DIRECTED_MAX + RANDOM_ITEMS)
            begin
                kind = $urandom_range(0, 9);
                fg   = $urandom;
                bg   = $urandom;
                if (kind == 0)
                begin
                    // Noise: every field fully random
                    send_req(1'($urandom_range(0, 1)), 13'($urandom), 13'($urandom),
                             13'($urandom), 13'($urandom), fg, bg, 8'($urandom));
                end
                else
                begin
                    bw = $urandom_range(1, 24);
                    bh = $urandom_range(1, 4);
                    rb = (bw + 7) / 8;
                    total = rb * bh;
                    case ($urandom_range(0, 3))
                        0:       dx = $urandom_range(0, 40) - 16;
                        1:       dx = cfg_w - $urandom_range(0, 20);
                        2:       dx = $urandom_range(0, cfg_w);
                        default: dx = $urandom_range(0, 8191) - 4096;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       dy = $urandom_range(0, 8) - 4;
                        1:       dy = cfg_h - $urandom_range(0, 6);
                        2:       dy = $urandom_range(0, cfg_h);
                        default: dy = $urandom_range(0, 8191) - 4096;
                    endcase
                    cut     = (kind == 1) ? $urandom_range(1, total) : total;
                    odd_idx = (kind == 2) ? $urandom_range(0, total - 1) : -1;
                    for (idx = 0; idx < cut; idx++)
                    begin
                        send_req(idx == 0, 13'(dx), 13'(dy),
                                 (idx == odd_idx) ? 13'($urandom_range(1, 24)) : 13'(bw),
                                 13'(bh), fg, bg, 8'($urandom));
                    end
                    if (kind == 3)
                    begin
                        send_req(1'b0, 13'(dx), 13'(dy), 13'(bw), 13'(bh), fg, bg,
                                 8'($urandom));
                    end
                end
                // Hold the sender once mid-phase until the output has caught up
                if (ph == 1 && !pause_done && items_sent + 12 > phase_end)
                begin
                    wait_idle();
                    pause_done = 1'b1;
                end
            end
            wait_idle();
        end

        wait_idle();
        if (sb.pending() != 0)
        begin
            report($sformatf("%0d pixel writes never arrived", sb.pending()));
        end
        if (err_count == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

>>> mono_bitmap_color_expander_core.f
hw/rtl/mbce_pkg.sv
hw/rtl/mbce_front.sv
hw/rtl/mbce_lane.sv
hw/rtl/mbce_merge.sv
hw/rtl/mono_bitmap_color_expander_core.sv
tb/tb_top.sv
